// ===== hw/rtl/tgbft_pkg.sv =====
// package: payload types, register indexes and controller states
`timescale 1ns / 1ps
`default_nettype none
package tgbft_pkg;

  // width of the free-running time base, elapsed time wraps at this width
  localparam int unsigned TIME_WIDTH = 32;

  typedef struct packed {
    logic             op;
    logic [31:0]      now_us;
    logic signed [19:0] foot_x_0;
    logic signed [19:0] foot_x_1;
    logic signed [19:0] foot_x_2;
    logic signed [19:0] foot_x_3;
    logic [3:0]       foot_valid;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         leg;
    logic signed [19:0] target_x;
    logic signed [19:0] target_z;
    logic               send_now;
    logic               last;
  } out_word_t;

  localparam logic [2:0] REG_PERIOD  = 3'd0;
  localparam logic [2:0] REG_STEP_L  = 3'd1;
  localparam logic [2:0] REG_STEP_H  = 3'd2;
  localparam logic [2:0] REG_STANCE  = 3'd3;
  localparam logic [2:0] REG_TURN    = 3'd4;

  localparam logic OP_ENTER = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_PHASE, ST_LEG, ST_DIV, ST_H1, ST_H2, ST_H3, ST_X, ST_Z1, ST_Z2,
    ST_OUT
  } state_e;

  // controller commands to datapath
  typedef struct packed {
    logic enter;     // record start, latch feet
    logic mod_init;  // start modulo of elapsed time
    logic mod_step;
    logic phase;     // swap test and record phase
    logic leg_init;  // per leg setup, start divide
    logic div_step;
    logic h1;
    logic h2;
    logic h3;
    logic xcalc;
    logic z1;
    logic z2;
    logic tick_done; // advance send slot
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tgbft_ctrl.sv =====
// controller: sequences the tick through modulo, per-leg divide and arithmetic
`timescale 1ns / 1ps
`default_nettype none
module tgbft_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          in_op_i,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  input  wire tgbft_pkg::sts_t sts_i,
  output tgbft_pkg::cmd_t    cmd_o,
  output logic [1:0]         leg_o
);
  import tgbft_pkg::*;

  state_e state_q, state_d;
  logic [1:0] leg_q, leg_d;

  // state and leg counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      leg_q   <= '0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
    end
  end

  assign leg_o = leg_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    leg_d       = leg_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_ENTER) begin
            cmd_o.enter = 1'b1;
          end else begin
            cmd_o.mod_init = 1'b1;
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) state_d = ST_PHASE;
      end
      ST_PHASE: begin
        cmd_o.phase = 1'b1;
        leg_d = '0;
        state_d = ST_LEG;
      end
      // leg setup sees the updated phase, pair and leg index
      ST_LEG: begin
        cmd_o.leg_init = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = ST_H1;
      end
      ST_H1: begin cmd_o.h1 = 1'b1; state_d = ST_H2; end
      ST_H2: begin cmd_o.h2 = 1'b1; state_d = ST_H3; end
      ST_H3: begin cmd_o.h3 = 1'b1; state_d = ST_X; end
      ST_X:  begin cmd_o.xcalc = 1'b1; state_d = ST_Z1; end
      ST_Z1: begin cmd_o.z1 = 1'b1; state_d = ST_Z2; end
      ST_Z2: begin cmd_o.z2 = 1'b1; state_d = ST_OUT; end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (leg_q == 2'd3) begin
            cmd_o.tick_done = 1'b1;
            state_d = ST_IDLE;
          end else begin
            leg_d = leg_q + 2'd1;
            state_d = ST_LEG;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tgbft_dp.sv =====
// datapath: gait registers, serial modulo and divide, smoothstep and target multipliers
`timescale 1ns / 1ps
`default_nettype none
module tgbft_dp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_idx_i,
  input  wire logic [31:0]     cfg_data_i,
  input  wire tgbft_pkg::in_word_t in_i,
  input  wire tgbft_pkg::cmd_t cmd_i,
  input  wire logic [1:0]      leg_i,
  output tgbft_pkg::sts_t      sts_o,
  output tgbft_pkg::out_word_t out_o
);
  import tgbft_pkg::*;

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned MCW = $clog2(TW + 1);

  // configuration registers
  logic [21:0] period_q;
  logic [18:0] step_l_q;
  logic [17:0] step_h_q;
  logic signed [19:0] stance_q;
  logic signed [17:0] turn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 22'd400000;
      step_l_q <= 19'd90000;
      step_h_q <= 18'd60000;
      stance_q <= -20'sd219000;
      turn_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD: period_q <= cfg_data_i[21:0];
        REG_STEP_L: step_l_q <= cfg_data_i[18:0];
        REG_STEP_H: step_h_q <= cfg_data_i[17:0];
        REG_STANCE: stance_q <= cfg_data_i[19:0];
        REG_TURN:   turn_q   <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  logic [21:0] p;
  assign p = (period_q == '0) ? 22'd1 : period_q;

  // gait state
  logic [TW-1:0] start_q;
  logic [21:0]   prev_q;
  logic          first_q, pairb_q;
  logic [1:0]    slot_q;
  logic signed [19:0] lx_q [4];
  logic [21:0]   t_q;
  in_word_t      in_q;

  // serial modulo: restoring remainder over elapsed bits
  logic [TW-1:0] el_q;
  logic [22:0]   rem_q;
  logic [MCW-1:0] mcnt_q;
  logic [22:0]   rem_sh, rem_sub;
  assign rem_sh  = {rem_q[21:0], el_q[TW-1]};
  assign rem_sub = rem_sh - {1'b0, p};

  // serial divide for phase fraction: (tp2 << 16) / p, 40 bit numerator
  logic [39:0]   num_q;
  logic [22:0]   drem_q;
  logic [39:0]   quo_q;
  logic [5:0]    dcnt_q;
  logic [22:0]   drem_sh, drem_sub;
  assign drem_sh  = {drem_q[21:0], num_q[39]};
  assign drem_sub = drem_sh - {1'b0, p};

  // per-leg values
  logic        swing, late;
  logic [22:0] t2;
  logic signed [24:0] tp2;
  logic [16:0] s_q;
  logic [33:0] s2_q;
  logic [48:0] h3_q;
  logic [16:0] h_q;
  logic signed [21:0] x_q;
  logic signed [21:0] z_q;
  logic [35:0] z1p_q;
  logic [16:0] s_c;
  logic signed [20:0] sl, end2;
  logic signed [22:0] dx;
  logic signed [40:0] prod;
  logic signed [41:0] xsum;
  logic signed [41:0] xr;
  logic [35:0] z1p;
  logic [52:0] z2p;
  logic [20:0] liftr;

  assign swing = (leg_i < 2'd2) ? !pairb_q : pairb_q;
  assign late  = (leg_i < 2'd2) ? !swing : swing;
  assign t2    = {t_q, 1'b0};
  assign tp2   = late ? ($signed({2'b0, t2}) - $signed({3'b0, p})) : $signed({2'b0, t2});
  assign s_c   = (quo_q > 40'd65536) ? 17'd65536 : quo_q[16:0];
  assign sl    = ((leg_i == 2'd0) || (leg_i == 2'd3))
                 ? ($signed({2'b0, step_l_q}) - 21'(turn_q))
                 : ($signed({2'b0, step_l_q}) + 21'(turn_q));
  assign end2  = swing ? sl : -sl;
  assign dx    = 23'(end2) - 23'($signed({lx_q[leg_i], 1'b0}));
  assign prod  = dx * $signed({1'b0, h_q});
  assign xsum  = ($signed(42'(lx_q[leg_i])) <<< 17) + 42'(prod) + 42'sd65536;
  assign xr    = xsum >>> 17;
  assign z1p   = {step_h_q, 2'b0} * 36'(s_q);
  assign z2p   = z1p_q * (17'd65536 - s_q);
  assign liftr = 21'((z2p + 53'h80000000) >> 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      prev_q  <= '0;
      first_q <= 1'b1;
      pairb_q <= 1'b0;
      slot_q  <= '0;
      for (int i = 0; i < 4; i++) lx_q[i] <= '0;
      mcnt_q  <= '0;
      dcnt_q  <= '0;
      in_q    <= '0;
    end else begin
      // enter: restart gait
      if (cmd_i.enter) begin
        start_q <= in_i.now_us[TW-1:0];
        first_q <= 1'b1;
        pairb_q <= 1'b0;
        if (in_i.foot_valid[0]) lx_q[0] <= in_i.foot_x_0;
        if (in_i.foot_valid[1]) lx_q[1] <= in_i.foot_x_1;
        if (in_i.foot_valid[2]) lx_q[2] <= in_i.foot_x_2;
        if (in_i.foot_valid[3]) lx_q[3] <= in_i.foot_x_3;
      end
      // modulo of elapsed time, tick word held for the swap latch
      if (cmd_i.mod_init) begin
        in_q   <= in_i;
        el_q   <= in_i.now_us[TW-1:0] - start_q;
        rem_q  <= '0;
        mcnt_q <= MCW'(TW);
      end else if (cmd_i.mod_step && mcnt_q != '0) begin
        el_q   <= {el_q[TW-2:0], 1'b0};
        rem_q  <= rem_sub[22] ? rem_sh : rem_sub;
        mcnt_q <= mcnt_q - 1'b1;
      end
      // swap test, feet latched on pair change
      if (cmd_i.phase) begin
        t_q <= rem_q[21:0];
        if (!first_q) begin
          if ({rem_q[21:0], 1'b0} < {1'b0, p} && {prev_q, 1'b0} > {1'b0, p}) begin
            pairb_q <= 1'b0;
            if (in_q.foot_valid[0]) lx_q[0] <= in_q.foot_x_0;
            if (in_q.foot_valid[1]) lx_q[1] <= in_q.foot_x_1;
            if (in_q.foot_valid[2]) lx_q[2] <= in_q.foot_x_2;
            if (in_q.foot_valid[3]) lx_q[3] <= in_q.foot_x_3;
          end else if ({rem_q[21:0], 1'b0} >= {1'b0, p} && {prev_q, 1'b0} < {1'b0, p}) begin
            pairb_q <= 1'b1;
            if (in_q.foot_valid[0]) lx_q[0] <= in_q.foot_x_0;
            if (in_q.foot_valid[1]) lx_q[1] <= in_q.foot_x_1;
            if (in_q.foot_valid[2]) lx_q[2] <= in_q.foot_x_2;
            if (in_q.foot_valid[3]) lx_q[3] <= in_q.foot_x_3;
          end
        end
        prev_q  <= rem_q[21:0];
        first_q <= 1'b0;
      end
      // phase fraction divide
      if (cmd_i.leg_init) begin
        num_q  <= tp2[24] ? 40'd0 : {tp2[23:0], 16'd0};
        drem_q <= '0;
        quo_q  <= '0;
        dcnt_q <= 6'd40;
      end else if (cmd_i.div_step && dcnt_q != '0) begin
        num_q  <= {num_q[38:0], 1'b0};
        drem_q <= drem_sub[22] ? drem_sh : drem_sub;
        quo_q  <= {quo_q[38:0], !drem_sub[22]};
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.tick_done) slot_q <= slot_q + 2'd1;
    end
  end

  // smoothstep and outputs, one multiply per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.h1) begin
      s_q  <= s_c;
      s2_q <= s_c * s_c;
    end
    if (cmd_i.h2) h3_q <= 49'(s2_q[32:0] * {32'd0, s_q});
    if (cmd_i.h3) h_q <= 17'((({16'd0, s2_q[32:0], 16'd0} * 65'd3) - {15'd0, h3_q, 1'b0}
                              + 65'h80000000) >> 32);
    if (cmd_i.xcalc) x_q <= 22'(xr);
    if (cmd_i.z1) z1p_q <= z1p;
    if (cmd_i.z2) z_q <= swing ? (22'(stance_q) + $signed({1'b0, liftr})) : 22'(stance_q);
  end

  // status to the controller
  assign sts_o.mod_done = (mcnt_q == '0);
  assign sts_o.div_done = (dcnt_q == '0);

  function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
    if (v > 22'sd524287) return 20'sd524287;
    if (v < -22'sd524288) return -20'sd524288;
    return v[19:0];
  endfunction

  assign out_o.leg      = leg_i;
  assign out_o.target_x = sat20(x_q);
  assign out_o.target_z = sat20(z_q);
  assign out_o.send_now = (leg_i == slot_q);
  assign out_o.last     = (leg_i == 2'd3);
endmodule
`default_nettype wire

// ===== hw/rtl/trot_gait_bezier_foot_trajectory.sv =====
// Trot gait foot target generator. An enter word is taken in idle and gives no
// result. A tick word passes its accept state, a bit-serial modulo of elapsed time
// and a phase state, then per leg a setup state, a serial divide for the phase
// fraction, the smoothstep, x and z arithmetic and an output state that waits on
// out_ready_i; no new word is taken until all four legs are out.
`timescale 1ns / 1ps
`default_nettype none
module trot_gait_bezier_foot_trajectory (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [2:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire tgbft_pkg::in_word_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output tgbft_pkg::out_word_t     out_data_o
);
  import tgbft_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [1:0] leg;

  assign cfg_ready_o = 1'b1;

  // sequencer
  tgbft_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i), .in_ready_o (in_ready_o), .in_op_i (in_data_i.op),
    .out_ready_i (out_ready_i), .out_valid_o (out_valid_o),
    .sts_i (sts), .cmd_o (cmd), .leg_o (leg)
  );

  // arithmetic and state
  tgbft_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i (cfg_valid_i), .cfg_idx_i (cfg_index_i), .cfg_data_i (cfg_data_i),
    .in_i (in_data_i), .cmd_i (cmd), .leg_i (leg), .sts_o (sts), .out_o (out_data_o)
  );
endmodule
`default_nettype wire

// ===== verif/trot_gait_bezier_foot_trajectory_test.sv =====
// testbench for the trot gait foot target generator: directed and random words checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module trot_gait_bezier_foot_trajectory_test;
  import tgbft_pkg::*;

  localparam logic OP_TICK = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = REG_PERIOD;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_word_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_data_o;

  trot_gait_bezier_foot_trajectory u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock and reset
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // gait model state and register copies
  longint          gait_period;
  longint          stride_len;
  longint          lift_height;
  longint          stance_z;
  longint          turn_diff;
  logic [31:0]     gait_start;
  longint unsigned last_phase;
  bit              first_tick;
  longint          foot_latch [4];
  bit              pair_b_swing;
  logic [1:0]      tx_slot;

  in_word_t  word_q [$];
  out_word_t gait_targets_q [$];
  int        fail_cnt = 0;
  int        words_sent = 0;
  int        words_taken = 0;
  int        targets_seen = 0;

  function automatic logic signed [19:0] clip20(input longint v);
    if (v > 524287) return 20'sh7FFFF;
    if (v < -524288) return 20'sh80000;
    return v[19:0];
  endfunction

  task automatic latch_feet(input in_word_t w);
    longint xs [4];
    xs[0] = w.foot_x_0;
    xs[1] = w.foot_x_1;
    xs[2] = w.foot_x_2;
    xs[3] = w.foot_x_3;
    for (int i = 0; i < 4; i++) begin
      if (w.foot_valid[i]) foot_latch[i] = xs[i];
    end
  endtask

  // work out the four leg targets that a tick word gives; an enter word restarts the model
  task automatic predict_gait(input in_word_t w);
    longint unsigned p, t, s, s2, s3, h, lift;
    logic [31:0]     elapsed;
    longint          tp2, sl, end2, x0, x, z;
    bit              swing, late;
    out_word_t       r;
    if (w.op == OP_ENTER) begin
      gait_start = w.now_us;
      first_tick = 1'b1;
      pair_b_swing = 1'b0;
      latch_feet(w);
      return;
    end
    p = (gait_period == 0) ? 1 : gait_period;
    elapsed = w.now_us - gait_start;
    t = longint'(elapsed) % p;
    // pair swap when the phase wraps or crosses half the period
    if (!first_tick) begin
      if (2 * t < p && 2 * last_phase > p) begin
        latch_feet(w);
        pair_b_swing = 1'b0;
      end else if (2 * t >= p && 2 * last_phase < p) begin
        latch_feet(w);
        pair_b_swing = 1'b1;
      end
    end
    last_phase = t;
    first_tick = 1'b0;
    for (int i = 0; i < 4; i++) begin
      swing = (i < 2) ? !pair_b_swing : pair_b_swing;
      late  = (i < 2) ? !swing : swing;
      tp2 = late ? longint'(2 * t) - longint'(p) : longint'(2 * t);
      if (tp2 < 0) tp2 = 0;
      s = (longint'(tp2) << 16) / p;
      if (s > 65536) s = 65536;
      s2 = s * s;
      s3 = s2 * s;
      h = (3 * (s2 << 16) - 2 * s3 + (64'd1 << 31)) >> 32;
      sl = (i == 0 || i == 3) ? stride_len - turn_diff : stride_len + turn_diff;
      end2 = swing ? sl : -sl;
      x0 = foot_latch[i];
      x = (x0 * 131072 + (end2 - 2 * x0) * longint'(h) + 65536) >>> 17;
      if (swing) begin
        lift = (4 * longint'(lift_height) * s * (65536 - s) + (64'd1 << 31)) >> 32;
        z = stance_z + longint'(lift);
      end else begin
        z = stance_z;
      end
      r.leg = i[1:0];
      r.target_x = clip20(x);
      r.target_z = clip20(z);
      r.send_now = (i[1:0] == tx_slot);
      r.last = (i == 3);
      gait_targets_q.push_back(r);
    end
    tx_slot = tx_slot + 2'd1;
  endtask

  // input driver: per word idle gap, bursts without gaps
  int in_gap = 0;
  bit in_burst = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || words_taken == words_sent) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap = in_gap - 1;
        end else if (word_q.size() != 0) begin
          in_data_i <= word_q.pop_front();
          in_valid_i <= 1'b1;
          words_sent = words_sent + 1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output stall driver: a new stall is drawn after every word taken
  int out_stall = 0;
  int targets_done = 0;
  bit out_burst = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (targets_seen != targets_done) begin
        targets_done = targets_seen;
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (out_stall != 0) begin
        out_ready_i <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // input acceptance feeds the predictor, output words are checked
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        words_taken = words_taken + 1;
        predict_gait(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        targets_seen = targets_seen + 1;
        if (gait_targets_q.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 10)
            $display("unexpected target word leg %0d x %0d z %0d", out_data_o.leg,
                     out_data_o.target_x, out_data_o.target_z);
        end else begin
          want = gait_targets_q.pop_front();
          if (out_data_o.leg !== want.leg || out_data_o.target_x !== want.target_x ||
              out_data_o.target_z !== want.target_z ||
              out_data_o.send_now !== want.send_now || out_data_o.last !== want.last) begin
            fail_cnt = fail_cnt + 1;
            if (fail_cnt <= 10)
              $display({"mismatch exp leg %0d x %0d z %0d send %0b last %0b, ",
                        "got leg %0d x %0d z %0d send %0b last %0b"},
                       want.leg, want.target_x, want.target_z, want.send_now, want.last,
                       out_data_o.leg, out_data_o.target_x, out_data_o.target_z,
                       out_data_o.send_now, out_data_o.last);
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_PERIOD: gait_period = val[21:0];
      REG_STEP_L: stride_len = val[18:0];
      REG_STEP_H: lift_height = val[17:0];
      REG_STANCE: stance_z = $signed(val[19:0]);
      REG_TURN:   turn_diff = $signed(val[17:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(input longint per, input longint sl, input longint sh,
                           input longint st, input longint tr);
    write_reg(REG_PERIOD, per[31:0]);
    write_reg(REG_STEP_L, sl[31:0]);
    write_reg(REG_STEP_H, sh[31:0]);
    write_reg(REG_STANCE, st[31:0]);
    write_reg(REG_TURN, tr[31:0]);
  endtask

  // wait until every word went in and every target came out
  task automatic settle();
    while (word_q.size() != 0 || in_valid_i || gait_targets_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_word_t make_word(input logic op, input logic [31:0] now,
                                         input logic [3:0] fv);
    in_word_t w;
    w.op = op;
    w.now_us = now;
    w.foot_x_0 = 20'($urandom);
    w.foot_x_1 = 20'($urandom);
    w.foot_x_2 = 20'($urandom);
    w.foot_x_3 = 20'($urandom);
    w.foot_valid = fv;
    return w;
  endfunction

  // enter then a run of advancing ticks, with some noise words mixed in
  task automatic gait_run(input int n);
    logic [31:0]     now;
    longint unsigned pe;
    pe = (gait_period == 0) ? 1 : gait_period;
    now = $urandom;
    word_q.push_back(make_word(OP_ENTER, now, 4'($urandom)));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        word_q.push_back(make_word(1'($urandom), $urandom, 4'($urandom)));
      end else begin
        now = now + $urandom_range(1, int'(pe / 3) + 1);
        word_q.push_back(make_word(OP_TICK, now, 4'($urandom)));
      end
    end
  endtask

  initial begin
    in_word_t w;
    gait_period = 400000;
    stride_len = 90000;
    lift_height = 60000;
    stance_z = -219000;
    turn_diff = 0;
    gait_start = '0;
    last_phase = 0;
    first_tick = 1'b1;
    foot_latch = '{0, 0, 0, 0};
    pair_b_swing = 1'b0;
    tx_slot = '0;
    wait (rst_ni);
    // directed: extremes of foot x, half period crossing, wrap, time wrap
    w = make_word(OP_ENTER, 32'd0, 4'hF);
    w.foot_x_0 = 20'sh7FFFF;
    w.foot_x_1 = 20'sh80000;
    w.foot_x_2 = 20'sd0;
    w.foot_x_3 = -20'sd1;
    word_q.push_back(w);
    word_q.push_back(make_word(OP_TICK, 32'd0, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd100000, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd199999, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd200000, 4'b0101));
    word_q.push_back(make_word(OP_TICK, 32'd300000, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd399999, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd400000, 4'b1010));
    word_q.push_back(make_word(OP_TICK, 32'd600000, 4'hF));
    word_q.push_back(make_word(OP_ENTER, 32'hFFFF_FF00, 4'h0));
    word_q.push_back(make_word(OP_TICK, 32'hFFFF_FFFF, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd50000, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd250000, 4'hF));
    word_q.push_back(make_word(OP_ENTER, 32'd1000, 4'hA));
    word_q.push_back(make_word(OP_TICK, 32'd1000, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd999, 4'hF));
    word_q.push_back(make_word(OP_TICK, 32'd1200, 4'hF));
    settle();
    // register extremes, zero period and random settings
    write_all(1000, 0, 0, 0, 0);
    gait_run(60);
    settle();
    write_all(4000000, 300000, 200000, -500000, -100000);
    gait_run(60);
    settle();
    write_all(0, 150000, 100000, -300000, 100000);
    gait_run(40);
    settle();
    write_all(4194303, 524287, 262143, -524288, -131072);
    gait_run(60);
    settle();
    for (int ph = 0; ph < 4; ph++) begin
      write_all($urandom_range(1000, 400000), $urandom_range(0, 300000),
                $urandom_range(0, 200000), -longint'($urandom_range(0, 500000)),
                longint'($urandom_range(0, 200000)) - 100000);
      gait_run(55);
      settle();
    end
    if (fail_cnt == 0) begin
      $display("trot_gait_bezier_foot_trajectory_test OK");
    end else begin
      $display("trot_gait_bezier_foot_trajectory_test NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("trot_gait_bezier_foot_trajectory_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
